// ===== src/pst_pkg.sv =====
// shared types and constants for the per-sender sequence tracker
`default_nettype none

package pst_pkg;

   // fixed field widths of the request and response items
   localparam int SENDER_W = 4;
   localparam int SEQ_W    = 8;
   localparam int STATUS_W = 2;
   localparam int NEXT_W   = 9;
   localparam int SLOT_W   = 10;

   // bitmap word scanned per step
   localparam int WORD_W = 16;
   localparam int WBIT_W = $clog2(WORD_W);

   // default sizing
   localparam int DEF_PEERS     = 16;
   localparam int DEF_MAX_SEQ   = 255;
   localparam int DEF_LOG_DEPTH = 1024;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_NEW = 2'd0,
      ST_DUP = 2'd1,
      ST_REJ = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== src/pst_if.sv =====
// request and response channel interfaces of the sequence tracker
`default_nettype none

interface pst_req_if
   import pst_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [SENDER_W-1:0] sender;
   logic [SEQ_W-1:0]  seq;

   modport source (output valid, output sender, output seq, input ready);
   modport sink   (input valid, input sender, input seq, output ready);
endinterface

interface pst_rsp_if
   import pst_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NEXT_W-1:0]   next_expected;
   logic [SLOT_W-1:0]   log_slot;

   modport source (output valid, output status, output next_expected, output log_slot,
                   input ready);
   modport sink   (input valid, input status, input next_expected, input log_slot,
                   output ready);
endinterface

`default_nettype wire

// ===== src/pst_scan.sv =====
// first-gap finder over one bitmap word, from a start bit upward
`default_nettype none

module pst_scan
   import pst_pkg::*;
   (
   input  wire logic [WORD_W-1:0] word,
   input  wire logic [WBIT_W-1:0] start,
   output logic                   found,
   output logic [WBIT_W-1:0]      index
);

   logic [WORD_W-1:0] masked;

   // clear bits at or above start, lowest one wins
   always_comb begin
      masked = ~word & ({WORD_W{1'b1}} << start);
      found  = |masked;
      index  = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (masked[i]) begin
            index = WBIT_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/pst_map.sv =====
// received bitmap memory, one word per row, registered read
`default_nettype none

module pst_map
   import pst_pkg::*;
   #(
   parameter int ROWS   = DEF_PEERS * ((DEF_MAX_SEQ + WORD_W - 1) / WORD_W),
   parameter int ROW_AW = $clog2(ROWS)
   ) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ROW_AW-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic [ROW_AW-1:0] rd_addr,
   output logic [WORD_W-1:0]      rd_data
);

   logic [WORD_W-1:0] mem [ROWS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/per_sender_sequence_tracker.sv =====
// per-sender sequence tracker: duplicate detection and next-expected tracking
//
// Takes message ids (sender, seq) on the req channel and returns one item per
// request on the rsp channel: status (new, duplicate or rejected), the
// sender's next expected sequence number and the log slot of a stored message.
// A bitmap of received numbers per sender lives in a single-port-write memory
// of WORD_W-bit rows; one first-gap finder walks it a row per cycle.
// A rejected id goes from S_IDLE straight to S_DONE, a duplicate or a full log
// passes S_CHECK, and a new message passes S_CHECK, S_SCAN_RD and S_SCAN, which
// scans bitmap rows up to the first gap (1 up to MAX_SEQ/WORD_W rounded up, 16
// at default). The request side is ready again the cycle after a result moves
// to the output register, so one item is in work at a time.
// The output register holds a result while rsp stalls; the next request is
// still taken and worked on, and only its hand-over waits for the register.
// After reset the bitmap is swept clean, one row per cycle, over all
// PEERS * ceil(MAX_SEQ / WORD_W) rows (256 at default); req.ready stays low
// during the sweep. Next-expected values reset to one, the stored count to 0.
`default_nettype none

module per_sender_sequence_tracker
   import pst_pkg::*;
   #(
   parameter int PEERS     = DEF_PEERS,
   parameter int MAX_SEQ   = DEF_MAX_SEQ,
   parameter int LOG_DEPTH = DEF_LOG_DEPTH
   ) (
   input  wire logic  clock,
   input  wire logic  reset,
   pst_req_if.sink    req,
   pst_rsp_if.source  rsp
);

   localparam int PEER_W  = $clog2(PEERS);
   localparam int SEQ_CW  = $clog2(MAX_SEQ + 2);
   localparam int XW      = SEQ_W + SEQ_CW;
   localparam int WORDS   = (MAX_SEQ + WORD_W - 1) / WORD_W;
   localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int ROWS    = PEERS * WORDS;
   localparam int ROW_AW  = $clog2(ROWS);
   localparam int CNT_W   = $clog2(LOG_DEPTH + 1);
   localparam int NW      = $clog2(WORDS * WORD_W + 1);
   localparam int SXW     = PEER_W + SENDER_W;

   state_type state_ff, state_in;

   logic [PEER_W-1:0]  peer_ff, peer_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [WBIT_W-1:0]  bit_ff, bit_in;
   logic [ROW_AW-1:0]  row_ff, row_in;
   logic [SEQ_CW-1:0]  expect_ff, expect_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WORD_AW-1:0] word_ff, word_in;
   logic [WBIT_W-1:0]  start_ff, start_in;
   status_type         status_ff, status_in;
   logic [SEQ_CW-1:0]  next_ff, next_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;
   logic [ROW_AW-1:0]  clr_ff, clr_in;
   logic [SEQ_CW-1:0]  next_seq_ff [PEERS];

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [NEXT_W-1:0]  rsp_next_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;

   // request decode
   logic               accept;
   logic [SXW-1:0]     sender_ext;
   logic               sender_ok;
   logic [PEER_W-1:0]  req_peer;
   logic [XW-1:0]      seq_wide;
   logic [XW-1:0]      seq_m1;
   logic               seq_bad;
   logic [WORD_AW-1:0] req_word;

   // check and scan helpers
   logic               hit;
   logic               log_full;
   logic [SEQ_CW-1:0]  expect_m1;
   logic [WORD_AW-1:0] first_word;
   logic [WORD_AW-1:0] word_inc;
   logic [NW-1:0]      gap_pos;
   logic [SEQ_CW-1:0]  gap_next;
   logic               out_free;

   // memory and finder ports
   logic               map_we;
   logic [ROW_AW-1:0]  map_waddr;
   logic [WORD_W-1:0]  map_wdata;
   logic [ROW_AW-1:0]  map_raddr;
   logic [WORD_W-1:0]  map_rdata;
   logic               scan_found;
   logic [WBIT_W-1:0]  scan_index;
   logic               nseq_we;

   pst_map #(
      .ROWS   (ROWS),
      .ROW_AW (ROW_AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   pst_scan u_scan (
      .word  (map_rdata),
      .start (start_ff),
      .found (scan_found),
      .index (scan_index)
   );

   // request side
   assign req.ready  = (state_ff == S_IDLE);
   assign accept     = req.valid && req.ready;
   assign sender_ext = {{PEER_W{1'b0}}, req.sender};
   assign sender_ok  = sender_ext < SXW'(PEERS);
   assign req_peer   = sender_ext[PEER_W-1:0];
   assign seq_wide   = {{SEQ_CW{1'b0}}, req.seq};
   assign seq_m1     = seq_wide - XW'(1);
   assign seq_bad    = (req.seq == '0) || (seq_wide > XW'(MAX_SEQ));
   assign req_word   = WORD_AW'(seq_m1 >> WBIT_W);

   // check and scan arithmetic
   assign hit        = (XW'(seq_ff) < XW'(expect_ff)) || map_rdata[bit_ff];
   assign log_full   = count_ff >= CNT_W'(LOG_DEPTH);
   assign expect_m1  = expect_ff - SEQ_CW'(1);
   assign first_word = WORD_AW'(expect_m1 >> WBIT_W);
   assign word_inc   = word_ff + WORD_AW'(1);
   assign gap_pos    = NW'({word_ff, scan_index}) + NW'(1);
   assign gap_next   = (gap_pos > NW'(MAX_SEQ + 1)) ? SEQ_CW'(MAX_SEQ + 1) : SEQ_CW'(gap_pos);
   assign out_free   = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ROW_AW'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = (!sender_ok || seq_bad) ? S_DONE : S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = (hit || log_full) ? S_DONE : S_SCAN_RD;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_found || (word_ff == WORD_AW'(WORDS - 1))) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // datapath control
   always_comb begin
      peer_in   = peer_ff;
      seq_in    = seq_ff;
      bit_in    = bit_ff;
      row_in    = row_ff;
      expect_in = expect_ff;
      count_in  = count_ff;
      word_in   = word_ff;
      start_in  = start_ff;
      status_in = status_ff;
      next_in   = next_ff;
      slot_in   = slot_ff;
      clr_in    = clr_ff;
      map_we    = 1'b0;
      map_waddr = row_ff;
      map_wdata = map_rdata | (WORD_W'(1) << bit_ff);
      map_raddr = ROW_AW'(ROW_AW'(req_peer) * ROW_AW'(WORDS) + ROW_AW'(req_word));
      nseq_we   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            clr_in    = clr_ff + ROW_AW'(1);
         end
         S_IDLE: begin
            if (accept) begin
               peer_in   = req_peer;
               seq_in    = req.seq;
               bit_in    = seq_m1[WBIT_W-1:0];
               row_in    = map_raddr;
               expect_in = sender_ok ? next_seq_ff[req_peer] : '0;
               status_in = ST_REJ;
               next_in   = sender_ok ? next_seq_ff[req_peer] : '0;
               slot_in   = '0;
            end
         end
         S_CHECK: begin
            next_in = expect_ff;
            slot_in = '0;
            if (hit) begin
               status_in = ST_DUP;
            end else if (log_full) begin
               status_in = ST_REJ;
            end else begin
               status_in = ST_NEW;
               map_we    = 1'b1;
               slot_in   = count_ff;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         S_SCAN_RD: begin
            word_in   = first_word;
            start_in  = expect_m1[WBIT_W-1:0];
            map_raddr = ROW_AW'(ROW_AW'(peer_ff) * ROW_AW'(WORDS) + ROW_AW'(first_word));
         end
         S_SCAN: begin
            map_raddr = ROW_AW'(ROW_AW'(peer_ff) * ROW_AW'(WORDS) + ROW_AW'(word_inc));
            if (scan_found) begin
               next_in = gap_next;
               nseq_we = 1'b1;
            end else if (word_ff == WORD_AW'(WORDS - 1)) begin
               next_in = SEQ_CW'(MAX_SEQ + 1);
               nseq_we = 1'b1;
            end else begin
               word_in  = word_inc;
               start_in = '0;
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next-expected table, one per sender
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PEERS; p++) begin
            next_seq_ff[p] <= SEQ_CW'(1);
         end
      end else if (nseq_we) begin
         next_seq_ff[peer_ff] <= next_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      peer_ff   <= peer_in;
      seq_ff    <= seq_in;
      bit_ff    <= bit_in;
      row_ff    <= row_in;
      expect_ff <= expect_in;
      word_ff   <= word_in;
      start_ff  <= start_in;
      status_ff <= status_in;
      next_ff   <= next_in;
      slot_ff   <= slot_in;
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_next_ff   <= NEXT_W'(next_ff);
         rsp_slot_ff   <= SLOT_W'(slot_ff);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.next_expected = rsp_next_ff;
   assign rsp.log_slot      = rsp_slot_ff;

   // stored count never passes the log depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LOG_DEPTH))
      else $error("stored count above log depth");

   // a store bumps the count by exactly one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && map_we) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("stored count did not advance on store");

   // scan stays inside the sender's rows
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (word_ff <= WORD_AW'(WORDS - 1)))
      else $error("bitmap scan ran past the last row");

   // next-expected never moves back and never lands on a newly stored number
   a_new_passes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff == ST_NEW) |->
         ((next_ff >= expect_ff) && (XW'(next_ff) != XW'(seq_ff))))
      else $error("next expected wrong after a newly stored item");

   // no item taken while the bitmap sweep runs
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !accept)
      else $error("item accepted during bitmap clear");

endmodule

`default_nettype wire

// ===== bench/tb_per_sender_sequence_tracker.sv =====
// testbench for the per-sender sequence tracker: directed, fill, mixed and log-full tests
`timescale 1ns / 1ps

module tb_per_sender_sequence_tracker
   import pst_pkg::*;
   ;

   localparam int PEERS      = DEF_PEERS;
   localparam int MAX_SEQ    = DEF_MAX_SEQ;
   localparam int LOG_DEPTH  = DEF_LOG_DEPTH;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 40;

   // one response item as the tracker should return it
   typedef struct packed {
      status_type        status;
      logic [NEXT_W-1:0] next_expected;
      logic [SLOT_W-1:0] log_slot;
   } verdict_type;

   logic clock;
   logic reset;

   pst_req_if req_if ();
   pst_rsp_if rsp_if ();

   per_sender_sequence_tracker #(
      .PEERS     (PEERS),
      .MAX_SEQ   (MAX_SEQ),
      .LOG_DEPTH (LOG_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // shadow copy of the tracker state
   bit               seen [PEERS][MAX_SEQ+1];
   logic [NEXT_W-1:0] next_exp [PEERS];
   int               stored;

   verdict_type pending_verdicts [$];

   int req_idle_pct;
   int rsp_idle_pct;
   int errors;
   int ids_sent;
   int new_seen;
   int dup_seen;
   int rej_seen;
   int cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // work out the verdict for one accepted id and advance the shadow state
   function automatic void track_id(logic [SENDER_W-1:0] s, logic [SEQ_W-1:0] q);
      verdict_type v;
      int n;
      v.log_slot      = '0;
      v.next_expected = next_exp[s];
      if (q == 0) begin
         v.status = ST_REJ;
      end else if (q < next_exp[s] || seen[s][q]) begin
         v.status = ST_DUP;
      end else if (stored >= LOG_DEPTH) begin
         v.status = ST_REJ;
      end else begin
         seen[s][q] = 1'b1;
         v.log_slot = stored[SLOT_W-1:0];
         stored++;
         n = next_exp[s];
         while (n <= MAX_SEQ && seen[s][n]) n++;
         next_exp[s]     = n[NEXT_W-1:0];
         v.next_expected = n[NEXT_W-1:0];
         v.status        = ST_NEW;
      end
      pending_verdicts.push_back(v);
   endfunction

   // send one message id, with a random gap first, and record it on accept
   task automatic send_id(input int s, input int q);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < req_idle_pct) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sender <= s[SENDER_W-1:0];
      req_if.seq    <= q[SEQ_W-1:0];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      track_id(s[SENDER_W-1:0], q[SEQ_W-1:0]);
      ids_sent++;
   endtask

   // pick a random id, biased toward in-order and near-order arrivals
   task automatic send_random_id();
      int s;
      int q;
      int kind;
      s    = $urandom_range(0, PEERS - 1);
      kind = $urandom_range(0, 99);
      if (kind < 50 && next_exp[s] <= MAX_SEQ) begin
         q = next_exp[s];
      end else if (kind < 68 && next_exp[s] <= MAX_SEQ) begin
         q = next_exp[s] + $urandom_range(1, 8);
         if (q > MAX_SEQ) q = MAX_SEQ;
      end else if (kind < 82 && next_exp[s] > 1) begin
         q = $urandom_range(1, next_exp[s] - 1);
      end else if (kind < 90) begin
         q = 0;
      end else begin
         q = $urandom_range(0, 255);
      end
      send_id(s, q);
   endtask

   // extremes of both fields, seq zero, both kinds of duplicate, gap filling
   task automatic test_directed();
      send_id(0, 0);
      send_id(0, 1);
      send_id(0, 1);
      send_id(0, 3);
      send_id(0, 3);
      send_id(0, 2);
      send_id(15, 255);
      send_id(15, 255);
      send_id(15, 0);
      send_id(15, 1);
      send_id(10, 170);
      send_id(5, 85);
      send_id(5, 1);
      send_id(10, 85);
   endtask

   // one sender receives every number in shuffled order until nothing is missing
   task automatic test_fill_sender();
      int order [MAX_SEQ];
      int i;
      int j;
      int t;
      for (i = 0; i < MAX_SEQ; i++) order[i] = i + 1;
      for (i = MAX_SEQ - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < MAX_SEQ; i++) send_id(9, order[i]);
      send_id(9, MAX_SEQ);
      send_id(9, 1);
      send_id(9, 0);
   endtask

   // mixed traffic across all senders
   task automatic test_mixed_traffic(input int count);
      repeat (count) send_random_id();
   endtask

   // fill the log, then check that new ids are refused while duplicates still report
   task automatic test_log_full(input int tail);
      int s;
      while (stored < LOG_DEPTH) begin
         s = $urandom_range(0, PEERS - 1);
         if (next_exp[s] <= MAX_SEQ) send_id(s, next_exp[s]);
      end
      send_id(0, 1);
      send_id(3, MAX_SEQ);
      send_id(12, 0);
      repeat (tail) send_random_id();
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin : check_rsp
      verdict_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("response with nothing expected: status %0d next %0d slot %0d",
                   rsp_if.status, rsp_if.next_expected, rsp_if.log_slot);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_if.status);
               errors++;
            end
            if (rsp_if.next_expected !== want.next_expected) begin
               $error("next_expected: expected %0d, got %0d",
                      want.next_expected, rsp_if.next_expected);
               errors++;
            end
            if (rsp_if.log_slot !== want.log_slot) begin
               $error("log_slot: expected %0d, got %0d", want.log_slot, rsp_if.log_slot);
               errors++;
            end
            case (want.status)
               ST_NEW:  new_seen++;
               ST_DUP:  dup_seen++;
               default: rej_seen++;
            endcase
         end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, pending_verdicts.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // test sequence
   initial begin
      int p;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.sender = '0;
      req_if.seq    = '0;
      rsp_if.ready  = 1'b0;
      errors        = 0;
      ids_sent      = 0;
      new_seen      = 0;
      dup_seen      = 0;
      rej_seen      = 0;
      cycles        = 0;
      stored        = 0;
      for (p = 0; p < PEERS; p++) next_exp[p] = 1;
      req_idle_pct  = 38;
      rsp_idle_pct  = 49;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_sender();

      req_idle_pct = 49;
      rsp_idle_pct = 38;
      test_mixed_traffic(1250);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_log_full(300);

      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d message ids: %0d stored, %0d duplicates, %0d rejected",
               ids_sent, new_seen, dup_seen, rej_seen);
      $display("log filled to %0d entries, sender 9 received in full", stored);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
